>>> design/assert_macros.svh
// Assertion macros used by the checker file of the maze walker.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/dmw_pkg.sv
// Shared types, codes and field layout for the depth-first maze walker.
// No dependencies; used by every RTL and checker file.
package dmw_pkg;

    localparam int GRID_W_DEF     = 32;
    localparam int GRID_H_DEF     = 32;
    localparam int PATH_DEPTH_DEF = 1024;

    localparam int COORD_W    = 5;
    localparam int HEAD_W     = 2;
    localparam int COUNT_W    = 16;
    localparam int DEPTH_W    = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 48;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [COORD_W-1:0] GOAL_RESET = 5'd31;

    // request kinds (s_tuser)
    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_STEP    = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFER_RIGHT = 3'd5;

    // headings and turns (added to the heading mod 4)
    localparam logic [HEAD_W-1:0] HEAD_UP    = 2'd0;
    localparam logic [HEAD_W-1:0] HEAD_RIGHT = 2'd1;
    localparam logic [HEAD_W-1:0] HEAD_DOWN  = 2'd2;
    localparam logic [HEAD_W-1:0] HEAD_LEFT  = 2'd3;
    localparam logic [HEAD_W-1:0] TURN_AHEAD = 2'd0;
    localparam logic [HEAD_W-1:0] TURN_RIGHT = 2'd1;
    localparam logic [HEAD_W-1:0] TURN_BACK  = 2'd2;
    localparam logic [HEAD_W-1:0] TURN_LEFT  = 2'd3;

    // s_tdata bits
    localparam int IN_LEFT_BIT  = 0;
    localparam int IN_AHEAD_BIT = 1;
    localparam int IN_RIGHT_BIT = 2;

    // m_tdata layout
    localparam int OUT_X_LO      = 0;
    localparam int OUT_Y_LO      = 5;
    localparam int OUT_HEAD_LO   = 10;
    localparam int OUT_MOVED_BIT = 12;
    localparam int OUT_BACK_BIT  = 13;
    localparam int OUT_GOAL_BIT  = 14;
    localparam int OUT_COUNT_LO  = 15;
    localparam int OUT_DEPTH_LO  = 31;
    localparam int OUT_FAULT_LO  = 42;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_PUSH
    } state_t;

    typedef enum logic [1:0] {
        FAULT_NONE,
        FAULT_STACK_FULL,
        FAULT_POP_EMPTY,
        FAULT_OFF_GRID
    } fault_t;

    // coordinate width: wide enough for the grid and for the 5-bit config fields
    function automatic int coord_width(input int cells);
        return ($clog2(cells) > COORD_W) ? $clog2(cells) : COORD_W;
    endfunction

endpackage

>>> design/dmw_target.sv
// Side selection and target-cell computation for one step of the walker.
// Depends on dmw_pkg.
module dmw_target #(
    parameter int GRID_W = dmw_pkg::GRID_W_DEF,
    parameter int GRID_H = dmw_pkg::GRID_H_DEF,
    localparam int XW = dmw_pkg::coord_width(GRID_W),
    localparam int YW = dmw_pkg::coord_width(GRID_H)
) (
    input  logic [XW-1:0]               cur_x,
    input  logic [YW-1:0]               cur_y,
    input  logic [dmw_pkg::HEAD_W-1:0]  cur_heading,
    input  logic                        prefer_right,
    input  logic                        open_left,
    input  logic                        open_ahead,
    input  logic                        open_right,
    output logic                        none_open,
    output logic [dmw_pkg::HEAD_W-1:0]  new_heading,
    output logic [XW:0]                 tgt_x,
    output logic [YW:0]                 tgt_y,
    output logic                        off_grid
);

    localparam logic [XW:0] GRID_W_C = (XW+1)'(GRID_W);
    localparam logic [YW:0] GRID_H_C = (YW+1)'(GRID_H);

    logic [dmw_pkg::HEAD_W-1:0] turn;
    logic                       wall_hit;

    // preferred hand, then ahead, then the other hand
    always_comb begin
        turn      = dmw_pkg::TURN_AHEAD;
        none_open = 1'b0;
        if (prefer_right) begin
            if (open_right)      turn = dmw_pkg::TURN_RIGHT;
            else if (open_ahead) turn = dmw_pkg::TURN_AHEAD;
            else if (open_left)  turn = dmw_pkg::TURN_LEFT;
            else                 none_open = 1'b1;
        end else begin
            if (open_left)       turn = dmw_pkg::TURN_LEFT;
            else if (open_ahead) turn = dmw_pkg::TURN_AHEAD;
            else if (open_right) turn = dmw_pkg::TURN_RIGHT;
            else                 none_open = 1'b1;
        end
    end

    assign new_heading = cur_heading + turn;

    always_comb begin
        tgt_x    = {1'b0, cur_x};
        tgt_y    = {1'b0, cur_y};
        wall_hit = 1'b0;
        case (new_heading)
            dmw_pkg::HEAD_UP: begin
                if (cur_y == '0) wall_hit = 1'b1;
                else             tgt_y = {1'b0, cur_y} - 1'b1;
            end
            dmw_pkg::HEAD_RIGHT: tgt_x = {1'b0, cur_x} + 1'b1;
            dmw_pkg::HEAD_DOWN:  tgt_y = {1'b0, cur_y} + 1'b1;
            default: begin
                if (cur_x == '0) wall_hit = 1'b1;
                else             tgt_x = {1'b0, cur_x} - 1'b1;
            end
        endcase
    end

    assign off_grid = wall_hit || (tgt_x >= GRID_W_C) || (tgt_y >= GRID_H_C);

endmodule

>>> design/dfs_maze_walker_core.sv
// Top level of the depth-first maze walker: visited-row memory, path stack
// memory, walker state and the request/result channels. Depends on dmw_pkg, dmw_target.
//
//   channel | dir | handshake              | payload
//   s_      | in  | s_tvalid / s_tready    | s_tuser = op, s_tdata = open bits
//   m_      | out | m_tvalid / m_tready    | m_tdata = walker state after request
//   cfg_    | in  | cfg_wr_en (no stall)   | cfg_index, cfg_wdata
//
// A step request reads the visited row of the target cell into a register at
// accept; in ST_EXEC the walker decides, writes the row back and loads the result.
// A step that pushes twice (forward move onto the goal) makes its second push in
// ST_PUSH: the path stack memory has one write port. A restart sweeps the visited
// memory one row per cycle in ST_CLEAR, holding the last row until its result can
// load. Reset starts the same sweep (no result); no request is taken until it ends.
// A result waiting in m_ does not block the next request; the decide cycle waits for it.
module dfs_maze_walker_core #(
    parameter int GRID_W     = dmw_pkg::GRID_W_DEF,
    parameter int GRID_H     = dmw_pkg::GRID_H_DEF,
    parameter int PATH_DEPTH = dmw_pkg::PATH_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dmw_pkg::S_TDATA_W-1:0]     s_tdata,   // open_left, open_ahead, open_right, 0...
    input  logic                              s_tuser,   // op: 0 restart, 1 step
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dmw_pkg::M_TDATA_W-1:0]     m_tdata,   // pos_x, pos_y, heading, moved,
                                                         // in_backtrack, at_goal, move_count,
                                                         // path_depth, fault, 0...
    // configuration writes
    input  logic                              cfg_wr_en,
    input  logic [dmw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dmw_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int XI = $clog2(GRID_W);             // column index into a visited row
    localparam int YI = $clog2(GRID_H);             // row address
    localparam int XW = dmw_pkg::coord_width(GRID_W);
    localparam int YW = dmw_pkg::coord_width(GRID_H);
    localparam int CW = $clog2(GRID_W * GRID_H);    // stacked cell number
    localparam int AW = $clog2(PATH_DEPTH);         // stack address
    localparam int TW = $clog2(PATH_DEPTH + 1);     // stack fill, 0..PATH_DEPTH

    localparam logic [XW:0]   GRID_W_C = (XW+1)'(GRID_W);
    localparam logic [YW:0]   GRID_H_C = (YW+1)'(GRID_H);
    localparam logic [TW-1:0] DEPTH_C  = TW'(PATH_DEPTH);
    localparam logic [YI-1:0] LAST_ROW = YI'(GRID_H - 1);
    localparam logic [CW-1:0] ROW_LEN  = CW'(GRID_W);

    typedef logic [GRID_W-1:0] row_t;

    // ---------------- configuration registers ----------------
    logic [dmw_pkg::COORD_W-1:0] start_x_reg, start_y_reg, goal_x_reg, goal_y_reg;
    logic [dmw_pkg::HEAD_W-1:0]  start_head_reg;
    logic                        prefer_right_reg;

    // ---------------- control and walker state ----------------
    dmw_pkg::state_t             state_reg, state_next;
    logic [YI-1:0]               clr_row_reg, clr_row_next;
    logic                        clr_item_reg, clr_item_next;   // restart owes a result
    logic                        mark_en_reg, mark_en_next;     // start cell inside grid
    logic [XI-1:0]               mark_x_reg, mark_x_next;
    logic [YI-1:0]               mark_y_reg, mark_y_next;

    logic [XW-1:0]               cur_x_reg, cur_x_next;
    logic [YW-1:0]               cur_y_reg, cur_y_next;
    logic [dmw_pkg::HEAD_W-1:0]  cur_head_reg, cur_head_next;
    logic                        retreat_reg, retreat_next;
    logic [dmw_pkg::COUNT_W-1:0] step_total_reg, step_total_next;
    logic [TW-1:0]               path_top_reg, path_top_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [dmw_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // ---------------- step target, captured at accept ----------------
    logic                        tg_none, tg_off;
    logic [dmw_pkg::HEAD_W-1:0]  tg_head;
    logic [XW:0]                 tg_x;
    logic [YW:0]                 tg_y;

    logic                        tgt_none_reg, tgt_off_reg;
    logic [dmw_pkg::HEAD_W-1:0]  tgt_head_reg;
    logic [XW:0]                 tgt_x_reg;
    logic [YW:0]                 tgt_y_reg;

    // second push of a step, done in ST_PUSH
    logic [AW-1:0]               push2_addr_reg, push2_addr_next;
    logic [CW-1:0]               push2_cell_reg, push2_cell_next;
    logic                        push_late;

    // ---------------- memories ----------------
    row_t                        seen_mem [GRID_H];
    row_t                        seen_rdata_reg;
    logic                        seen_re, seen_we;
    logic [YI-1:0]               seen_raddr, seen_waddr;
    row_t                        seen_wdata;

    logic [CW-1:0]               path_mem [PATH_DEPTH];
    logic                        path_we;
    logic [AW-1:0]               path_waddr;
    logic [CW-1:0]               path_wdata;

    // ---------------- handshake helpers ----------------
    logic accept, out_free, exec_fire, clr_last, clr_done, out_load;
    logic res_moved;
    dmw_pkg::fault_t res_fault;
    logic res_at_goal;

    logic at_goal_cur, stack_full, seen_bit, start_on_goal, start_in_grid;
    logic [CW-1:0] cur_cell, tgt_cell, start_cell;

    assign s_tready  = (state_reg == dmw_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign exec_fire = (state_reg == dmw_pkg::ST_EXEC) && out_free;
    assign clr_last  = (state_reg == dmw_pkg::ST_CLEAR) && (clr_row_reg == LAST_ROW);
    assign clr_done  = clr_last && (!clr_item_reg || out_free);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    dmw_target #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H)
    ) u_target (
        .cur_x        (cur_x_reg),
        .cur_y        (cur_y_reg),
        .cur_heading  (cur_head_reg),
        .prefer_right (prefer_right_reg),
        .open_left    (s_tdata[dmw_pkg::IN_LEFT_BIT]),
        .open_ahead   (s_tdata[dmw_pkg::IN_AHEAD_BIT]),
        .open_right   (s_tdata[dmw_pkg::IN_RIGHT_BIT]),
        .none_open    (tg_none),
        .new_heading  (tg_head),
        .tgt_x        (tg_x),
        .tgt_y        (tg_y),
        .off_grid     (tg_off)
    );

    // cell numbers as stacked: y * GRID_W + x
    assign cur_cell   = CW'(cur_y_reg) * ROW_LEN + CW'(cur_x_reg);
    assign tgt_cell   = CW'(tgt_y_reg) * ROW_LEN + CW'(tgt_x_reg);
    assign start_cell = CW'(start_y_reg) * ROW_LEN + CW'(start_x_reg);

    assign at_goal_cur   = (cur_x_reg == XW'(goal_x_reg)) && (cur_y_reg == YW'(goal_y_reg));
    assign stack_full    = (path_top_reg >= DEPTH_C);
    assign seen_bit      = seen_rdata_reg[tgt_x_reg[XI-1:0]];
    assign start_on_goal = (start_x_reg == goal_x_reg) && (start_y_reg == goal_y_reg);
    assign start_in_grid = ({1'b0, XW'(start_x_reg)} < GRID_W_C)
                        && ({1'b0, YW'(start_y_reg)} < GRID_H_C);

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dmw_pkg::ST_CLEAR: begin
                if (clr_done) state_next = dmw_pkg::ST_IDLE;
            end
            dmw_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (s_tuser == dmw_pkg::OP_RESTART) ? dmw_pkg::ST_CLEAR
                                                                  : dmw_pkg::ST_EXEC;
                end
            end
            dmw_pkg::ST_EXEC: begin
                if (exec_fire) state_next = push_late ? dmw_pkg::ST_PUSH : dmw_pkg::ST_IDLE;
            end
            dmw_pkg::ST_PUSH: state_next = dmw_pkg::ST_IDLE;
            default:          state_next = dmw_pkg::ST_IDLE;
        endcase
    end

    // ---------------- datapath and memory ports ----------------
    always_comb begin
        logic [TW-1:0] top_mid;
        logic          push_first;
        logic          go;

        clr_row_next    = clr_row_reg;
        clr_item_next   = clr_item_reg;
        mark_en_next    = mark_en_reg;
        mark_x_next     = mark_x_reg;
        mark_y_next     = mark_y_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        cur_head_next   = cur_head_reg;
        retreat_next    = retreat_reg;
        step_total_next = step_total_reg;
        path_top_next   = path_top_reg;
        push2_addr_next = push2_addr_reg;
        push2_cell_next = push2_cell_reg;
        push_late       = 1'b0;

        seen_re    = 1'b0;
        seen_raddr = tg_y[YI-1:0];
        seen_we    = 1'b0;
        seen_waddr = tgt_y_reg[YI-1:0];
        seen_wdata = seen_rdata_reg | (row_t'(1) << tgt_x_reg[XI-1:0]);

        path_we    = 1'b0;
        path_waddr = path_top_reg[AW-1:0];
        path_wdata = cur_cell;

        out_load   = 1'b0;
        res_moved  = 1'b0;
        res_fault  = dmw_pkg::FAULT_NONE;
        top_mid    = path_top_reg;
        push_first = 1'b0;
        go         = 1'b0;

        case (state_reg)
            dmw_pkg::ST_CLEAR: begin
                // sweep rows; the start row gets its start bit on the way
                seen_we    = 1'b1;
                seen_waddr = clr_row_reg;
                seen_wdata = (mark_en_reg && (clr_row_reg == mark_y_reg))
                           ? (row_t'(1) << mark_x_reg) : '0;
                if (!clr_last) clr_row_next = clr_row_reg + 1'b1;
                if (clr_done) begin
                    clr_row_next  = '0;
                    clr_item_next = 1'b0;
                    out_load      = clr_item_reg;
                end
            end

            dmw_pkg::ST_IDLE: begin
                if (accept) begin
                    seen_re = 1'b1;
                    if (s_tuser == dmw_pkg::OP_RESTART) begin
                        cur_x_next      = XW'(start_x_reg);
                        cur_y_next      = YW'(start_y_reg);
                        cur_head_next   = start_head_reg;
                        retreat_next    = 1'b0;
                        step_total_next = '0;
                        path_top_next   = start_on_goal ? TW'(1) : '0;
                        path_we         = start_on_goal;
                        path_waddr      = '0;
                        path_wdata      = start_cell;
                        clr_item_next   = 1'b1;
                        mark_en_next    = start_in_grid;
                        mark_x_next     = XI'(start_x_reg);
                        mark_y_next     = YI'(start_y_reg);
                    end
                end
            end

            dmw_pkg::ST_EXEC: begin
                if (exec_fire) begin
                    out_load = 1'b1;
                    if (!at_goal_cur) begin
                        if (step_total_reg != dmw_pkg::COUNT_MAX)
                            step_total_next = step_total_reg + 1'b1;

                        if (tgt_none_reg) begin
                            // dead end: no side is open; push and turn round unless already retreating
                            if (!retreat_reg) begin
                                if (stack_full) begin
                                    res_fault = dmw_pkg::FAULT_STACK_FULL;
                                end else begin
                                    push_first    = 1'b1;
                                    top_mid       = path_top_reg + 1'b1;
                                    cur_head_next = cur_head_reg + dmw_pkg::TURN_BACK;
                                    retreat_next  = 1'b1;
                                end
                            end
                        end else if (tgt_off_reg) begin
                            res_fault = dmw_pkg::FAULT_OFF_GRID;
                        end else if (!retreat_reg) begin
                            if (stack_full) begin
                                res_fault = dmw_pkg::FAULT_STACK_FULL;
                            end else begin
                                push_first = 1'b1;
                                top_mid    = path_top_reg + 1'b1;
                                go         = 1'b1;
                            end
                        end else if (!seen_bit) begin
                            retreat_next = 1'b0;
                            go           = 1'b1;
                        end else if (path_top_reg == '0) begin
                            res_fault = dmw_pkg::FAULT_POP_EMPTY;
                        end else begin
                            top_mid = path_top_reg - 1'b1;
                            go      = 1'b1;
                        end

                        path_we       = push_first;
                        path_top_next = top_mid;

                        if (go) begin
                            cur_head_next = tgt_head_reg;
                            cur_x_next    = tgt_x_reg[XW-1:0];
                            cur_y_next    = tgt_y_reg[YW-1:0];
                            seen_we       = 1'b1;
                            res_moved     = 1'b1;
                            if ((tgt_x_reg[XW-1:0] == XW'(goal_x_reg))
                                    && (tgt_y_reg[YW-1:0] == YW'(goal_y_reg))) begin
                                if (top_mid >= DEPTH_C) begin
                                    res_fault = dmw_pkg::FAULT_STACK_FULL;
                                end else begin
                                    path_top_next = top_mid + 1'b1;
                                    if (push_first) begin
                                        push_late       = 1'b1;
                                        push2_addr_next = top_mid[AW-1:0];
                                        push2_cell_next = tgt_cell;
                                    end else begin
                                        path_we    = 1'b1;
                                        path_waddr = top_mid[AW-1:0];
                                        path_wdata = tgt_cell;
                                    end
                                end
                            end
                        end
                    end
                end
            end

            dmw_pkg::ST_PUSH: begin
                path_we    = 1'b1;
                path_waddr = push2_addr_reg;
                path_wdata = push2_cell_reg;
            end

            default: ;
        endcase

        res_at_goal = (cur_x_next == XW'(goal_x_reg)) && (cur_y_next == YW'(goal_y_reg));
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (out_load) m_tvalid_next = 1'b1;
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg      <= '0;
            start_y_reg      <= '0;
            start_head_reg   <= dmw_pkg::HEAD_UP;
            goal_x_reg       <= dmw_pkg::GOAL_RESET;
            goal_y_reg       <= dmw_pkg::GOAL_RESET;
            prefer_right_reg <= 1'b0;
            // reset acts as a restart from the reset start cell, without a result
            state_reg        <= dmw_pkg::ST_CLEAR;
            clr_row_reg      <= '0;
            clr_item_reg     <= 1'b0;
            mark_en_reg      <= 1'b1;
            mark_x_reg       <= '0;
            mark_y_reg       <= '0;
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            cur_head_reg     <= dmw_pkg::HEAD_UP;
            retreat_reg      <= 1'b0;
            step_total_reg   <= '0;
            path_top_reg     <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    dmw_pkg::CFG_START_X:      start_x_reg      <= cfg_wdata;
                    dmw_pkg::CFG_START_Y:      start_y_reg      <= cfg_wdata;
                    dmw_pkg::CFG_START_HEAD:   start_head_reg   <= cfg_wdata[dmw_pkg::HEAD_W-1:0];
                    dmw_pkg::CFG_GOAL_X:       goal_x_reg       <= cfg_wdata;
                    dmw_pkg::CFG_GOAL_Y:       goal_y_reg       <= cfg_wdata;
                    dmw_pkg::CFG_PREFER_RIGHT: prefer_right_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            state_reg      <= state_next;
            clr_row_reg    <= clr_row_next;
            clr_item_reg   <= clr_item_next;
            mark_en_reg    <= mark_en_next;
            mark_x_reg     <= mark_x_next;
            mark_y_reg     <= mark_y_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            cur_head_reg   <= cur_head_next;
            retreat_reg    <= retreat_next;
            step_total_reg <= step_total_next;
            path_top_reg   <= path_top_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            tgt_none_reg <= tg_none;
            tgt_off_reg  <= tg_off;
            tgt_head_reg <= tg_head;
            tgt_x_reg    <= tg_x;
            tgt_y_reg    <= tg_y;
        end
        push2_addr_reg <= push2_addr_next;
        push2_cell_reg <= push2_cell_next;
        if (out_load) begin
            m_tdata_reg <= {4'b0000,
                            res_fault,
                            dmw_pkg::DEPTH_W'(path_top_next),
                            step_total_next,
                            res_at_goal,
                            retreat_next,
                            res_moved,
                            cur_head_next,
                            dmw_pkg::COORD_W'(cur_y_next),
                            dmw_pkg::COORD_W'(cur_x_next)};
        end
    end

    // visited rows: read at accept, written back in the decide cycle, so a
    // read never meets a write to the same row in flight
    always_ff @(posedge aclk) begin
        if (seen_we) seen_mem[seen_waddr] <= seen_wdata;
        if (seen_re) seen_rdata_reg <= seen_mem[seen_raddr];
    end

    // path stack
    always_ff @(posedge aclk) begin
        if (path_we) path_mem[path_waddr] <= path_wdata;
    end

endmodule

>>> design/dmw_checker.sv
// Port-level checks on the maze walker top level, bound in below.
// Depends on dmw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dmw_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dmw_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [1:0] out_fault;
    logic       out_moved, out_back;

    assign out_fault = m_tdata[dmw_pkg::OUT_FAULT_LO +: 2];
    assign out_moved = m_tdata[dmw_pkg::OUT_MOVED_BIT];
    assign out_back  = m_tdata[dmw_pkg::OUT_BACK_BIT];

    // one request in flight at a time
    `ASSERT_NEXT(a_one_request, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request accepted while busy")

    // stalled result holds
    `ASSERT_NEXT(a_result_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // empty-stack pop only while retreating, and the agent stays put
    `ASSERT_SAME(a_pop_fault, aclk, aresetn, m_tvalid && (out_fault == dmw_pkg::FAULT_POP_EMPTY), !out_moved && out_back, "pop fault with move or outside backtrack")

    // an off-grid move is blocked
    `ASSERT_SAME(a_off_fault, aclk, aresetn, m_tvalid && (out_fault == dmw_pkg::FAULT_OFF_GRID), !out_moved, "off-grid fault with move")

endmodule

bind dfs_maze_walker_core dmw_checker u_dmw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
